[sv/pfi_pkg.sv]
// ----------------------------------------------------------------------------
// pfi_pkg
// shared types and constants for the q31 polyphase interpolator
// ----------------------------------------------------------------------------
`default_nettype none
package pfi_pkg;
  localparam int unsigned MaxFactorDef    = 8;
  localparam int unsigned MaxPhaseTapsDef = 16;
  localparam int unsigned CoefDepthDef    = 128;
  localparam int unsigned QShift          = 31;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_COEF  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [0:0] REG_FACTOR = 1'b0;
  localparam logic [0:0] REG_PLEN   = 1'b1;

  // controls handed along the history cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic rotate;
  } cell_ctl_t;
endpackage
`default_nettype wire

[sv/pfi_if.sv]
// ----------------------------------------------------------------------------
// pfi_in_if / pfi_out_if
// valid/ready channels of the interpolator
// ----------------------------------------------------------------------------
`default_nettype none
interface pfi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] sample_in;
  logic [6:0]         coef_index;
  logic signed [31:0] coef_value;
  modport source (output valid, opcode, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, opcode, sample_in, coef_index, coef_value, output ready);
endinterface

interface pfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;
  logic               last_of_run;
  modport source (output valid, sample_out, last_of_run, input ready);
  modport sink   (input valid, sample_out, last_of_run, output ready);
endinterface
`default_nettype wire

[sv/polyphase_fir_interpolator_q31_top.sv]
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_q31_top
// q31 polyphase fir interpolator by factor L
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one command per transfer: push sample, write coefficient,
//   clear history. a push yields L transfers on out_if, phases L-1 down to 0,
//   last_of_run marking phase 0. apb port writes interp_factor (0x0) and
//   phase_len (0x4) while idle, a rule for the user the block does not enforce.
//   the history is a row of MAX_PHASE_TAPS cells; a push shifts it by one.
//   during a phase pass the row rotates one cell per cycle, so the mac always
//   sees cell 0 while the coefficient ram is read at p + k*L.
//   a push runs one pass of L phases through the single mac, and no further
//   command is taken until the pass ends. each phase rotates the full row
//   (only the newest phase_len taps accumulate), then drains the ram read
//   and multiply registers and presents the result.
//   a stalled receiver holds the result register; the next phase still runs,
//   then waits with its sum held until the result register frees up.
//   reset clears the history and registers; coefficients are undefined
//   until written.
// ----------------------------------------------------------------------------
`default_nettype none
module polyphase_fir_interpolator_q31_top #(
  parameter int unsigned MAX_FACTOR     = pfi_pkg::MaxFactorDef,
  parameter int unsigned MAX_PHASE_TAPS = pfi_pkg::MaxPhaseTapsDef,
  parameter int unsigned COEF_DEPTH     = pfi_pkg::CoefDepthDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  pfi_in_if.sink       in_if,
  pfi_out_if.source    out_if,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pfi_pkg::*;
  localparam int unsigned TW = (MAX_PHASE_TAPS > 1) ? $clog2(MAX_PHASE_TAPS) : 1;
  localparam int unsigned AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int unsigned FW = $clog2(MAX_FACTOR + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_e;

  // config registers
  logic [3:0] factor_q;
  logic [4:0] plen_q;
  logic       cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= 4'd1;
      plen_q   <= 5'd1;
    end else if (cfg_we && paddr[2] == REG_PLEN) begin
      plen_q <= pwdata[4:0];
    end else if (cfg_we && paddr[2] == REG_FACTOR) begin
      factor_q <= pwdata[3:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PLEN) prdata[4:0] = plen_q;
    else prdata[3:0] = factor_q;
  end

  // clamped settings
  logic [FW-1:0] lf;
  logic [8:0]    plen;
  always_comb begin
    if (factor_q == 4'd0) lf = FW'(1);
    else if (32'(factor_q) > MAX_FACTOR) lf = FW'(MAX_FACTOR);
    else lf = FW'(factor_q);
    if (plen_q == 5'd0) plen = 9'd1;
    else if (32'(plen_q) > MAX_PHASE_TAPS) plen = 9'(MAX_PHASE_TAPS);
    else plen = 9'(plen_q);
  end

  // coefficient store
  logic [31:0] coef_mem [COEF_DEPTH];
  logic [31:0] coef_rd_q;
  logic        cmd_coef;
  logic        in_take;

  state_e        state_q;
  logic [TW-1:0] pos_q;        // row position being read this cycle
  logic [FW-1:0] phase_q;
  logic [15:0]   addr_q;       // phase + k*L, k relative to base
  logic          v1_q, z1_q, v2_q;  // ram stage, multiply stage valid
  logic [1:0]    drain_q;
  logic          out_valid_q, out_last_q;
  logic [31:0]   out_data_q;
  logic [31:0]   samp_q;       // cell 0 delayed to line up with ram read
  logic          out_load;     // result register takes the finished sum

  assign in_take  = in_if.valid && in_if.ready;
  assign cmd_coef = in_take && in_if.opcode == OP_COEF;
  always_ff @(posedge clk_i) begin
    if (cmd_coef && 32'(in_if.coef_index) < COEF_DEPTH) begin
      coef_mem[AW'(in_if.coef_index)] <= in_if.coef_value;
    end
    coef_rd_q <= coef_mem[AW'(addr_q)];
  end

  // history cell row
  cell_ctl_t   ctl;
  logic [31:0] words [MAX_PHASE_TAPS];
  always_comb begin
    ctl.shift  = in_take && in_if.opcode == OP_PUSH;
    ctl.clear  = in_take && in_if.opcode == OP_CLEAR;
    ctl.rotate = (state_q == S_RUN);
  end
  for (genvar g = 0; g < MAX_PHASE_TAPS; g++) begin : g_row
    pfi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .shift_in_i ((g == MAX_PHASE_TAPS - 1) ? in_if.sample_in : words[(g + 1) % MAX_PHASE_TAPS]),
      .rot_in_i   (words[(g + 1) % MAX_PHASE_TAPS]),
      .word_o     (words[g])
    );
  end

  // tap k lives at row position base + k; valid when pos >= base
  logic [8:0] base;
  logic       tap_on;
  assign base   = 9'(MAX_PHASE_TAPS) - plen;
  assign tap_on = (9'(pos_q) >= base);

  // the sum is held while the result register is still occupied
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  logic [63:0] acc;
  pfi_mac u_mac (
    .clk_i      (clk_i),
    .mul_en_i   (1'b1),
    .mul_zero_i (!v1_q || z1_q),
    .a_i        (coef_rd_q),
    .b_i        (samp_q),
    .acc_clr_i  (state_q == S_IDLE || out_load),
    .acc_en_i   (v2_q),
    .acc_o      (acc)
  );

  assign in_if.ready = (state_q == S_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      phase_q     <= '0;
      addr_q      <= '0;
      v1_q        <= 1'b0;
      z1_q        <= 1'b0;
      v2_q        <= 1'b0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
      samp_q      <= '0;
    end else begin
      samp_q <= words[0];
      v2_q   <= v1_q;
      v1_q   <= (state_q == S_RUN) && tap_on;
      z1_q   <= (32'(addr_q) >= COEF_DEPTH);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_take && in_if.opcode == OP_PUSH) begin
            state_q <= S_RUN;
            phase_q <= lf - FW'(1);
            pos_q   <= '0;
            addr_q  <= 16'(lf - FW'(1));
          end
        end
        S_RUN: begin
          if (tap_on) addr_q <= addr_q + 16'(lf);
          if (32'(pos_q) == MAX_PHASE_TAPS - 1) begin
            state_q <= S_DRAIN;
            drain_q <= '0;
          end
          pos_q <= (32'(pos_q) == MAX_PHASE_TAPS - 1) ? '0 : pos_q + TW'(1);
        end
        S_DRAIN: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'd2) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_q  <= acc[62:31];
            out_last_q  <= (phase_q == '0);
            if (phase_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RUN;
              phase_q <= phase_q - FW'(1);
              addr_q  <= 16'(phase_q - FW'(1));
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.sample_out  = out_data_q;
  assign out_if.last_of_run = out_last_q;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_data_q))
    else $error("result changed under stall");
  // no input accepted during a pass
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready)
    else $error("input taken mid pass");
  // a pass starts only from a push
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !(in_take && in_if.opcode == OP_PUSH) |=> state_q == S_IDLE)
    else $error("spurious pass");
endmodule
`default_nettype wire

[sv/pfi_cell.sv]
// ----------------------------------------------------------------------------
// pfi_cell
// one history word: clears on clear, shifts on push, rotates toward the mac during a pass
// ----------------------------------------------------------------------------
`default_nettype none
module pfi_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pfi_pkg::cell_ctl_t  ctl_i,
  input  wire [31:0]          shift_in_i,
  input  wire [31:0]          rot_in_i,
  output logic [31:0]         word_o
);
  import pfi_pkg::*;
  logic [31:0] word_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (ctl_i.clear) begin
      word_q <= '0;
    end else if (ctl_i.shift) begin
      word_q <= shift_in_i;
    end else if (ctl_i.rotate) begin
      word_q <= rot_in_i;
    end
  end
  assign word_o = word_q;
endmodule
`default_nettype wire

[sv/pfi_mac.sv]
// ----------------------------------------------------------------------------
// pfi_mac
// registered 32x32 multiply then 64-bit accumulate
// ----------------------------------------------------------------------------
`default_nettype none
module pfi_mac (
  input  wire         clk_i,
  input  wire         mul_en_i,
  input  wire         mul_zero_i,
  input  wire [31:0]  a_i,
  input  wire [31:0]  b_i,
  input  wire         acc_clr_i,
  input  wire         acc_en_i,
  output logic [63:0] acc_o
);
  import pfi_pkg::*;
  logic [63:0] prod_q, acc_q;
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= mul_zero_i ? 64'd0 : 64'($signed(a_i) * $signed(b_i));
    end
    if (acc_clr_i) begin
      acc_q <= '0;
    end else if (acc_en_i) begin
      acc_q <= acc_q + prod_q;
    end
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the q31 polyphase interpolator against a bit-accurate predictor
// ----------------------------------------------------------------------------
// commands go in through a queue-fed driver and results are checked by a
// monitor. phases: directed corners, then random traffic under several
// factor / length settings, including out-of-range register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pfi_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [31:0] smp;
    logic [6:0]  cidx;
    logic [31:0] cval;
  } cmd_t;

  typedef struct packed {
    logic [31:0] smp;
    logic        last;
  } res_t;

  localparam int unsigned WdogLimit = 20000;
  // coefficients loaded up front; settings keep L * phase_len within this span
  localparam int unsigned CoefSpan = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pfi_in_if  in_if ();
  pfi_out_if out_if ();

  polyphase_fir_interpolator_q31_top u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] hist_q [MaxPhaseTapsDef];
  logic [31:0] coef_q [CoefDepthDef];
  logic [3:0]  factor_q = 4'd1;
  logic [4:0]  plen_q = 5'd1;

  cmd_t cmd_queue [$];
  res_t expected_outputs [$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;

  // effective settings after clamping
  function automatic int unsigned eff_factor();
    if (factor_q == 0) return 1;
    if (factor_q > MaxFactorDef) return MaxFactorDef;
    return factor_q;
  endfunction

  function automatic int unsigned eff_plen();
    if (plen_q == 0) return 1;
    if (plen_q > MaxPhaseTapsDef) return MaxPhaseTapsDef;
    return plen_q;
  endfunction

  // apply one accepted command, queueing the interpolated outputs
  task automatic interpolate(input cmd_t c);
    int unsigned lf, pl, base, addr;
    logic [63:0] acc;
    logic signed [63:0] prod;
    res_t r;
    lf = eff_factor();
    pl = eff_plen();
    base = MaxPhaseTapsDef - pl;
    case (c.op)
      OP_COEF: begin
        coef_q[c.cidx] = c.cval;
      end
      OP_CLEAR: begin
        foreach (hist_q[i]) hist_q[i] = '0;
      end
      OP_PUSH: begin
        for (int i = 0; i < MaxPhaseTapsDef - 1; i++) hist_q[i] = hist_q[i + 1];
        hist_q[MaxPhaseTapsDef - 1] = c.smp;
        for (int p = lf - 1; p >= 0; p--) begin
          acc = '0;
          for (int k = 0; k < pl; k++) begin
            addr = p + k * lf;
            if (addr < CoefDepthDef) begin
              prod = $signed(coef_q[addr]) * $signed(hist_q[base + k]);
              acc += prod;
            end
          end
          r.smp = acc[62:31];
          r.last = (p == 0);
          expected_outputs.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // transfers seen at the last rising edge
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      out_fire <= out_if.valid && out_if.ready;
    end
  end

  // driver: pending commands with random gaps
  int unsigned send_gap = 0;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.opcode <= OP_NONE;
      in_if.sample_in <= '0;
      in_if.coef_index <= '0;
      in_if.coef_value <= '0;
      send_gap <= 0;
    end else if (in_if.valid && !in_fire) begin
      // hold the pending transfer
    end else if (send_gap != 0) begin
      in_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (cmd_queue.size() != 0) begin
      cmd_t c;
      c = cmd_queue.pop_front();
      in_if.valid <= 1'b1;
      in_if.opcode <= c.op;
      in_if.sample_in <= c.smp;
      in_if.coef_index <= c.cidx;
      in_if.coef_value <= c.cval;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern
  int unsigned recv_gap = 0;
  int unsigned recv_draw = 0;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap != 0) begin
      out_if.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (out_fire) begin
      // one transfer completed; draw a fresh wait for the next one
      recv_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (recv_draw == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        recv_gap <= recv_draw - 1;
      end
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        cmd_t c;
        c.op = op_e'(in_if.opcode);
        c.smp = in_if.sample_in;
        c.cidx = in_if.coef_index;
        c.cval = in_if.coef_value;
        interpolate(c);
      end
      if (out_if.valid && out_if.ready) begin
        res_t e;
        if (expected_outputs.size() == 0) begin
          $error("unexpected output sample_out=%h last_of_run=%b",
                 out_if.sample_out, out_if.last_of_run);
          errors++;
        end else begin
          e = expected_outputs.pop_front();
          if (out_if.sample_out !== e.smp) begin
            $error("sample_out expected %h actual %h", e.smp, out_if.sample_out);
            errors++;
          end
          if (out_if.last_of_run !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, out_if.last_of_run);
            errors++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles >= WdogLimit && !stim_done) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // apb register write (setup then access phase), only while idle
  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_FACTOR) factor_q = val[3:0];
    else plen_q = val[4:0];
  endtask

  // wait until the queue has drained and all outputs arrived
  task automatic drain();
    while (cmd_queue.size() != 0 || in_if.valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic cmd_t mk(input op_e op, input logic [31:0] s,
                              input logic [6:0] ci, input logic [31:0] cv);
    cmd_t c;
    c.op = op; c.smp = s; c.cidx = ci; c.cval = cv;
    return c;
  endfunction

  // write the coefficient span so no unwritten entry is ever read
  task automatic load_coefs();
    for (int i = 0; i < CoefSpan; i++)
      cmd_queue.push_back(mk(OP_COEF, $urandom, i[6:0], $urandom));
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 13)
        cmd_queue.push_back(mk(OP_PUSH, $urandom, 7'($urandom), $urandom));
      else if (r < 17)
        cmd_queue.push_back(mk(OP_COEF, $urandom, 7'($urandom), $urandom));
      else if (r < 19)
        cmd_queue.push_back(mk(OP_CLEAR, $urandom, 7'($urandom), $urandom));
      else
        cmd_queue.push_back(mk(OP_NONE, $urandom, 7'($urandom), $urandom));
    end
  endtask

  initial begin
    int unsigned f, pmax;
    foreach (hist_q[i]) hist_q[i] = '0;
    foreach (coef_q[i]) coef_q[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners at reset settings
    load_coefs();
    cmd_queue.push_back(mk(OP_COEF, '0, 7'd0, 32'h8000_0000));
    cmd_queue.push_back(mk(OP_PUSH, 32'h8000_0000, '0, '0));
    cmd_queue.push_back(mk(OP_PUSH, 32'h7fff_ffff, '0, '0));
    cmd_queue.push_back(mk(OP_COEF, '0, 7'd0, 32'h7fff_ffff));
    cmd_queue.push_back(mk(OP_PUSH, 32'h7fff_ffff, '0, '0));
    cmd_queue.push_back(mk(OP_PUSH, 32'hffff_ffff, '0, '0));
    cmd_queue.push_back(mk(OP_NONE, 32'h1234_5678, 7'h7f, 32'hdead_beef));
    cmd_queue.push_back(mk(OP_CLEAR, '0, '0, '0));
    cmd_queue.push_back(mk(OP_PUSH, 32'h0000_0001, '0, '0));
    drain();

    // max factor over the loaded span, full-scale extremes
    reg_write(REG_FACTOR, 32'd8);
    reg_write(REG_PLEN, 32'd8);
    cmd_queue.push_back(mk(OP_COEF, '0, 7'd127, 32'h8000_0000));
    for (int i = 0; i < 4; i++)
      cmd_queue.push_back(mk(OP_PUSH, (i[0]) ? 32'h8000_0000 : 32'h7fff_ffff, '0, '0));
    random_phase(6);
    drain();

    // out-of-range values clamp
    reg_write(REG_FACTOR, 32'd0);
    reg_write(REG_PLEN, 32'd0);
    random_phase(6);
    drain();
    reg_write(REG_FACTOR, 32'd15);
    reg_write(REG_PLEN, 32'd8);
    random_phase(5);
    drain();
    reg_write(REG_FACTOR, 32'd4);
    reg_write(REG_PLEN, 32'd31);
    random_phase(5);
    drain();

    // random settings
    for (int ph = 0; ph < 2; ph++) begin
      f = $urandom_range(1, 8);
      pmax = (CoefSpan / f > MaxPhaseTapsDef) ? MaxPhaseTapsDef : CoefSpan / f;
      reg_write(REG_FACTOR, f);
      reg_write(REG_PLEN, $urandom_range(1, pmax));
      random_phase(6);
      drain();
    end

    stim_done = 1'b1;
    if (errors == 0 && expected_outputs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
